// ===== design/lpe_pkg.sv =====
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types, constants and helper functions for the LCD pixel engine.
// ----------------------------------------------------------------------------
package lpe_pkg;

  // Default pixel FIFO depth and the fixed visible width.
  localparam int FifoDepthDef = 8;
  localparam int ScreenWidth  = 160;

  // Line timing.
  localparam logic [8:0] DOTS_LAST   = 9'd455;
  localparam logic [8:0] OAM_DOTS    = 9'd80;
  localparam logic [8:0] HBLANK_DOT  = 9'd368;
  localparam logic [7:0] VBLANK_LINE = 8'd144;
  localparam logic [7:0] LAST_LINE   = 8'd153;
  localparam logic [7:0] LAST_VIS    = 8'd143;

  // Video memory offsets of the two tile maps and the signed tile base.
  localparam logic [12:0] MAP_LOW_OFS  = 13'h1800;
  localparam logic [12:0] MAP_HIGH_OFS = 13'h1C00;
  localparam logic [12:0] TILE_SGN_OFS = 13'h1000;

  // Item opcodes.
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_RD   = 2'd1,
    OP_WR   = 2'd2,
    OP_VWR  = 2'd3
  } op_t;

  // LCD modes.
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  // Register offsets.
  localparam logic [7:0] REG_LCDC = 8'h40;
  localparam logic [7:0] REG_STAT = 8'h41;
  localparam logic [7:0] REG_SCY  = 8'h42;
  localparam logic [7:0] REG_SCX  = 8'h43;
  localparam logic [7:0] REG_LY   = 8'h44;
  localparam logic [7:0] REG_LYC  = 8'h45;
  localparam logic [7:0] REG_BGP  = 8'h47;
  localparam logic [7:0] REG_OBP0 = 8'h48;
  localparam logic [7:0] REG_OBP1 = 8'h49;
  localparam logic [7:0] REG_WY   = 8'h4A;
  localparam logic [7:0] REG_WX   = 8'h4B;
  localparam logic [7:0] REG_BCPS = 8'h68;
  localparam logic [7:0] REG_BCPD = 8'h69;
  localparam logic [7:0] REG_OCPS = 8'h6A;
  localparam logic [7:0] REG_OCPD = 8'h6B;

  // Fetcher stages.
  localparam logic [2:0] FS_MAP  = 3'd0;
  localparam logic [2:0] FS_LO   = 3'd2;
  localparam logic [2:0] FS_HI   = 3'd4;
  localparam logic [2:0] FS_PUSH = 3'd6;

  // Kind of a video memory read whose data lands in the cycle after the request.
  typedef enum logic [1:0] {
    VQ_MAP = 2'd0,
    VQ_LO  = 2'd1,
    VQ_HI  = 2'd2
  } vq_kind_t;

  // Video memory request.
  typedef struct packed {
    logic        en;
    logic        we;
    logic [12:0] addr;
    logic [7:0]  wdata;
  } vram_req_t;

  // Colour palette RAM request.
  typedef struct packed {
    logic       en;
    logic       we;
    logic [1:0] be;
    logic [5:0] addr;
    logic [7:0] wdata;
  } cpal_req_t;

  // Partial result of one item, completed with palette RAM data later.
  typedef struct packed {
    logic [7:0]  read_data;
    logic        pal_rd;
    logic        pal_hi;
    logic        pal_pix;
    logic        pixel_valid;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [14:0] rgb;
    logic        vblank;
    logic        frame_done;
    logic [1:0]  mode;
  } res_t;

  // Fixed grey shades for mono mode.
  function automatic logic [14:0] grey_shade(input logic [1:0] s);
    logic [14:0] g;
    case (s)
      2'd0:    g = 15'h7FFF;
      2'd1:    g = 15'h56B5;
      2'd2:    g = 15'h294A;
      default: g = 15'h0000;
    endcase
    return g;
  endfunction

  // Five-bit channel to eight bits.
  function automatic logic [7:0] expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  // Video memory offset of a tile row.
  function automatic logic [12:0] tile_row_ofs(input logic [7:0] id, input logic [2:0] row,
                                               input logic uns);
    logic [12:0] base;
    base = (uns || id[7]) ? 13'h0000 : TILE_SGN_OFS;
    return base + {1'b0, id, 4'b0000} + {9'b0, row, 1'b0};
  endfunction

endpackage

// ===== design/handheld_lcd_pixel_engine.sv =====
// ----------------------------------------------------------------------------
// handheld_lcd_pixel_engine
// Background-only handheld LCD controller with tile fetcher and palettes.
// ----------------------------------------------------------------------------
// Every item (dot tick, register read or write, video memory write) is taken
// when offered and not stalled, so the block sustains one item per cycle while
// the output is not stalled. Its result passes the synchronous read of the video
// memory or the colour palette RAM, then the output register. Tile map and
// tile row bytes read from video memory are folded into the fetcher
// state in the cycle after the read. The colour palette RAM clears at reset
// through per-byte valid bits, so no clearing pass is needed. Video memory
// is not cleared and must be written before its bytes are fetched.
// ----------------------------------------------------------------------------
module handheld_lcd_pixel_engine
  import lpe_pkg::*;
#(
  parameter int FIFO_DEPTH = FifoDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_reg_offset,
  input  logic [12:0] in_vram_offset,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_pixel_valid,
  output logic [7:0]  out_pixel_column,
  output logic [7:0]  out_pixel_row,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_vblank_pulse,
  output logic        out_frame_done,
  output logic [1:0]  out_lcd_mode
);

  logic        acc, r1_adv;
  logic        r1_v_r, r1_v_nxt, o_v_r, o_v_nxt;
  res_t        res, r1_r;
  vram_req_t   vreq;
  cpal_req_t   preq;
  logic [7:0]  vram_q;
  logic [15:0] cpal_q;
  logic [14:0] rgb;
  logic [7:0]  o_rd_r, o_col_r, o_row_r, o_red_r, o_grn_r, o_blu_r;
  logic        o_pv_r, o_vb_r, o_fd_r;
  logic [1:0]  o_mode_r;

  lpe_engine #(.FIFO_DEPTH(FIFO_DEPTH)) u_engine (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .acc,
    .opcode(in_opcode), .reg_offset(in_reg_offset), .vram_offset(in_vram_offset),
    .write_data(in_write_data), .vram_q, .vreq, .preq, .res
  );

  lpe_vram u_vram (.clk, .req(vreq), .q(vram_q));

  lpe_cpal u_cpal (.clk, .rst_n, .req(preq), .q(cpal_q));

  // Two-stage result pipeline: memory read stage, then output register.
  assign r1_adv   = r1_v_r && (!o_v_r || !out_stall);
  assign in_stall = r1_v_r && !r1_adv;
  assign acc      = in_valid && !in_stall;
  assign r1_v_nxt = acc || (r1_v_r && !r1_adv);
  assign o_v_nxt  = r1_adv || (o_v_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      r1_v_r <= r1_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      r1_r <= res;
    end
  end

  // Complete the result with palette RAM data.
  assign rgb = r1_r.pal_pix ? cpal_q[14:0] : r1_r.rgb;

  always_ff @(posedge clk) begin
    if (r1_adv) begin
      o_rd_r   <= r1_r.pal_rd ? (r1_r.pal_hi ? cpal_q[15:8] : cpal_q[7:0]) : r1_r.read_data;
      o_pv_r   <= r1_r.pixel_valid;
      o_col_r  <= r1_r.column;
      o_row_r  <= r1_r.row;
      o_red_r  <= r1_r.pixel_valid ? expand5(rgb[4:0]) : 8'd0;
      o_grn_r  <= r1_r.pixel_valid ? expand5(rgb[9:5]) : 8'd0;
      o_blu_r  <= r1_r.pixel_valid ? expand5(rgb[14:10]) : 8'd0;
      o_vb_r   <= r1_r.vblank;
      o_fd_r   <= r1_r.frame_done;
      o_mode_r <= r1_r.mode;
    end
  end

  assign out_valid        = o_v_r;
  assign out_read_data    = o_rd_r;
  assign out_pixel_valid  = o_pv_r;
  assign out_pixel_column = o_col_r;
  assign out_pixel_row    = o_row_r;
  assign out_red          = o_red_r;
  assign out_green        = o_grn_r;
  assign out_blue         = o_blu_r;
  assign out_vblank_pulse = o_vb_r;
  assign out_frame_done   = o_fd_r;
  assign out_lcd_mode     = o_mode_r;

  // An accepted item always finds room in the read stage.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (r1_v_r && !r1_adv) |-> !acc)
    else $error("item accepted over a held item");

  // A palette RAM read is only issued for an accepted item.
  a_pal_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (preq.en && !preq.we) |-> acc)
    else $error("palette read without an item");

  // Emitted pixels lie on visible lines and columns.
  a_pix_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel_valid) |-> (out_pixel_row < VBLANK_LINE &&
                                         out_pixel_column < 8'(ScreenWidth)))
    else $error("pixel outside the screen");

  // A vblank result always reports mode one.
  a_vb_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_vblank_pulse) |-> out_lcd_mode == MODE_VBLANK)
    else $error("vblank without vblank mode");

endmodule

// ===== design/lpe_vram.sv =====
// ----------------------------------------------------------------------------
// lpe_vram
// 8 KiB video memory, one port, registered read data.
// ----------------------------------------------------------------------------
module lpe_vram
  import lpe_pkg::*;
(
  input  logic      clk,
  input  vram_req_t req,
  output logic [7:0] q
);

  logic [7:0] mem [8192];
  logic [7:0] q_r;

  // Write or read one byte; the read data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        q_r <= mem[req.addr];
      end
    end
  end

  assign q = q_r;

endmodule

// ===== design/lpe_cpal.sv =====
// ----------------------------------------------------------------------------
// lpe_cpal
// Colour palette RAM, 64 entries of 16 bits with byte lanes and reset-clear.
// ----------------------------------------------------------------------------
module lpe_cpal
  import lpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cpal_req_t   req,
  output logic [15:0] q
);

  logic [15:0] mem [64];
  logic [15:0] q_r;
  logic [1:0]  vld_r [64];
  logic [1:0]  qv_r;

  // Byte lane writes and registered read.
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        if (req.be[0]) begin
          mem[req.addr][7:0] <= req.wdata;
        end
        if (req.be[1]) begin
          mem[req.addr][15:8] <= req.wdata;
        end
      end else begin
        q_r <= mem[req.addr];
      end
    end
  end

  // Per-lane valid bits; an unwritten lane reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 64; i++) begin
        vld_r[i] <= 2'b00;
      end
      qv_r <= 2'b00;
    end else if (req.en) begin
      if (req.we) begin
        vld_r[req.addr] <= vld_r[req.addr] | req.be;
      end else begin
        qv_r <= vld_r[req.addr];
      end
    end
  end

  assign q = {q_r[15:8] & {8{qv_r[1]}}, q_r[7:0] & {8{qv_r[0]}}};

endmodule

// ===== design/lpe_engine.sv =====
// ----------------------------------------------------------------------------
// lpe_engine
// Register file, dot and line timer, background fetcher and pixel FIFO.
// ----------------------------------------------------------------------------
module lpe_engine
  import lpe_pkg::*;
#(
  parameter int FIFO_DEPTH = FifoDepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       acc,
  input  logic [1:0] opcode,
  input  logic [7:0] reg_offset,
  input  logic [12:0] vram_offset,
  input  logic [7:0] write_data,
  input  logic [7:0] vram_q,
  output vram_req_t  vreq,
  output cpal_req_t  preq,
  output res_t       res
);

  localparam int HW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic          cmode_r;
  logic [7:0]    lcdc_r, lcdc_nxt, stat_r, stat_nxt, scy_r, scy_nxt, scx_r, scx_nxt;
  logic [7:0]    ly_r, ly_nxt, lyc_r, lyc_nxt;
  logic [7:0]    mono_r [3];
  logic [7:0]    mono_nxt [3];
  logic [7:0]    wpos_r [2];
  logic [7:0]    wpos_nxt [2];
  logic [6:0]    pidx_r [2];
  logic [6:0]    pidx_nxt [2];
  logic [8:0]    dot_r, dot_nxt;
  logic [2:0]    fine_r, fine_nxt, stage_r, stage_nxt, skip_r, skip_nxt;
  logic [7:0]    fcol_r, fcol_nxt, ocol_r, ocol_nxt;
  logic [12:0]   tra_r, tra_nxt;
  logic [7:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic [1:0]    fifo_r [FIFO_DEPTH];
  logic [1:0]    fifo_nxt [FIFO_DEPTH];
  logic [HW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          vpend_r, vpend_nxt;
  vq_kind_t      vkind_r, vkind_nxt;
  logic [2:0]    vrow_r, vrow_nxt;
  logic          vuns_r, vuns_nxt;

  // Next-state logic for one accepted item plus late video memory data.
  always_comb begin
    logic [7:0]  y, x, sx, rdv, line_n;
    logic [12:0] mapa;
    logic [5:0]  pidx6;
    logic [3:0]  n;
    logic [1:0]  pix, mode_v;
    logic        which;
    logic [8:0]  dot_p;

    lcdc_nxt = lcdc_r; stat_nxt = stat_r; scy_nxt = scy_r; scx_nxt = scx_r;
    ly_nxt = ly_r; lyc_nxt = lyc_r;
    mono_nxt = mono_r; wpos_nxt = wpos_r; pidx_nxt = pidx_r;
    dot_nxt = dot_r; fine_nxt = fine_r; stage_nxt = stage_r; skip_nxt = skip_r;
    fcol_nxt = fcol_r; ocol_nxt = ocol_r; tra_nxt = tra_r;
    lo_nxt = lo_r; hi_nxt = hi_r; fifo_nxt = fifo_r; head_nxt = head_r; cnt_nxt = cnt_r;
    vpend_nxt = 1'b0; vkind_nxt = vkind_r; vrow_nxt = vrow_r; vuns_nxt = vuns_r;
    vreq = '0; preq = '0; res = '0;
    y = '0; x = '0; sx = '0; rdv = '0; line_n = '0; mapa = '0; pidx6 = '0;
    n = '0; pix = '0; dot_p = '0;
    which = reg_offset[1];
    mode_v = stat_r[1:0];

    // Video memory data of the previous cycle's read.
    if (vpend_r) begin
      case (vkind_r)
        VQ_MAP:  tra_nxt = tile_row_ofs(vram_q, vrow_r, vuns_r);
        VQ_LO:   lo_nxt = vram_q << skip_r;
        VQ_HI:   hi_nxt = vram_q << skip_r;
        default: ;
      endcase
    end

    if (acc) begin
      case (op_t'(opcode))
        OP_RD: begin
          case (reg_offset)
            REG_LCDC: rdv = lcdc_r;
            REG_STAT: rdv = stat_r;
            REG_SCY:  rdv = scy_r;
            REG_SCX:  rdv = scx_r;
            REG_LY:   rdv = ly_r;
            REG_LYC:  rdv = lyc_r;
            REG_BGP:  rdv = mono_r[0];
            REG_OBP0: rdv = mono_r[1];
            REG_OBP1: rdv = mono_r[2];
            REG_WY:   rdv = wpos_r[0];
            REG_WX:   rdv = wpos_r[1];
            REG_BCPD, REG_OCPD: begin
              pidx6 = pidx_r[which][5:0];
              preq.en = 1'b1;
              preq.addr = {which, pidx6[5:1]};
              res.pal_rd = 1'b1;
              res.pal_hi = pidx6[0];
            end
            default: rdv = '0;
          endcase
          res.read_data = rdv;
        end
        OP_WR: begin
          case (reg_offset)
            REG_LCDC: lcdc_nxt = write_data;
            REG_STAT: stat_nxt = {write_data[7:3], stat_r[2:0]};
            REG_SCY:  scy_nxt = write_data;
            REG_SCX:  scx_nxt = write_data;
            REG_LYC:  lyc_nxt = write_data;
            REG_BGP:  mono_nxt[0] = write_data;
            REG_OBP0: mono_nxt[1] = write_data;
            REG_OBP1: mono_nxt[2] = write_data;
            REG_WY:   wpos_nxt[0] = write_data;
            REG_WX:   wpos_nxt[1] = write_data;
            REG_BCPS, REG_OCPS: pidx_nxt[which] = {write_data[7], write_data[5:0]};
            REG_BCPD, REG_OCPD: begin
              pidx6 = pidx_r[which][5:0];
              preq.en = 1'b1;
              preq.we = 1'b1;
              preq.be = pidx6[0] ? 2'b10 : 2'b01;
              preq.addr = {which, pidx6[5:1]};
              preq.wdata = write_data;
              if (pidx_r[which][6]) begin
                pidx_nxt[which] = {1'b1, pidx6 + 6'd1};
              end
            end
            default: ;
          endcase
        end
        OP_VWR: begin
          vreq.en = 1'b1;
          vreq.we = 1'b1;
          vreq.addr = vram_offset;
          vreq.wdata = write_data;
        end
        default: begin
          // Dot tick.
          stat_nxt[2] = (ly_r == lyc_r);
          if (ly_r < VBLANK_LINE) begin
            if (dot_r == '0) begin
              fine_nxt = scx_r[2:0];
            end
            if (dot_r > OAM_DOTS && stat_r[1:0] == MODE_DRAW) begin
              case (stage_r)
                FS_MAP: begin
                  y = scy_r + ly_r;
                  sx = {scx_r[7:3], fine_r};
                  x = sx + fcol_r;
                  mapa = (lcdc_r[3] ? MAP_HIGH_OFS : MAP_LOW_OFS) +
                         {3'b000, y[7:3], x[7:3]};
                  vreq.en = 1'b1;
                  vreq.addr = mapa;
                  vpend_nxt = 1'b1;
                  vkind_nxt = VQ_MAP;
                  vrow_nxt = y[2:0];
                  vuns_nxt = lcdc_r[4];
                  skip_nxt = x[2:0];
                  stage_nxt = stage_r + 3'd1;
                end
                FS_LO, FS_HI: begin
                  vreq.en = 1'b1;
                  vreq.addr = (stage_r == FS_LO) ? tra_r : tra_r + 13'd1;
                  vpend_nxt = 1'b1;
                  vkind_nxt = (stage_r == FS_LO) ? VQ_LO : VQ_HI;
                  stage_nxt = stage_r + 3'd1;
                end
                3'd1, 3'd3, 3'd5: stage_nxt = stage_r + 3'd1;
                default: begin
                  // Push the fetched row into an empty FIFO.
                  if (cnt_r == '0) begin
                    n = 4'd8 - {1'b0, skip_r};
                    for (int k = 0; k < 8; k++) begin
                      fifo_nxt[k] = {hi_r[7-k], lo_r[7-k]};
                    end
                    head_nxt = '0;
                    cnt_nxt = CW'(n);
                    stage_nxt = FS_MAP;
                    fcol_nxt = fcol_r + {4'b0000, n};
                  end
                end
              endcase
              if (dot_r == HBLANK_DOT) begin
                mode_v = MODE_HBLANK;
              end
            end
            // Emit one pixel.
            if (ocol_r < 8'(ScreenWidth) && cnt_nxt != '0) begin
              pix = fifo_nxt[head_nxt];
              head_nxt = (head_nxt == HW'(FIFO_DEPTH - 1)) ? '0 : head_nxt + 1'b1;
              cnt_nxt = cnt_nxt - 1'b1;
              res.pixel_valid = 1'b1;
              res.column = ocol_r;
              res.row = ly_r;
              if (cmode_r) begin
                preq.en = 1'b1;
                preq.addr = {4'b0000, pix};
                res.pal_pix = 1'b1;
              end else begin
                res.rgb = grey_shade(mono_r[0][{pix, 1'b0} +: 2]);
              end
              ocol_nxt = ocol_r + 8'd1;
            end
          end
          // Timer.
          dot_p = dot_r + 9'd1;
          if (dot_r == DOTS_LAST) begin
            line_n = ly_r + 8'd1;
            if (line_n == VBLANK_LINE) begin
              mode_v = MODE_VBLANK;
              res.vblank = 1'b1;
            end else if (ly_r == LAST_LINE) begin
              line_n = '0;
              mode_v = MODE_OAM;
            end else if (line_n < VBLANK_LINE) begin
              mode_v = MODE_OAM;
            end
            dot_nxt = '0;
            fcol_nxt = '0;
            ly_nxt = line_n;
          end else begin
            dot_nxt = dot_p;
            if (dot_p == OAM_DOTS && ly_r < VBLANK_LINE) begin
              mode_v = MODE_DRAW;
              head_nxt = '0;
              cnt_nxt = '0;
              ocol_nxt = '0;
              stage_nxt = FS_MAP;
            end
          end
          stat_nxt[1:0] = mode_v;
          res.frame_done = (ocol_nxt == 8'(ScreenWidth)) && (ly_nxt == LAST_VIS);
        end
      endcase
    end
    res.mode = stat_nxt[1:0];
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmode_r <= 1'b0;
      lcdc_r <= '0; stat_r <= '0; scy_r <= '0; scx_r <= '0; ly_r <= '0; lyc_r <= '0;
      for (int i = 0; i < 3; i++) mono_r[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        wpos_r[i] <= '0;
        pidx_r[i] <= '0;
      end
      dot_r <= '0; fine_r <= '0; stage_r <= '0; skip_r <= '0;
      fcol_r <= '0; ocol_r <= '0; head_r <= '0; cnt_r <= '0;
      vpend_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cmode_r <= cfg_wdata;
      end
      lcdc_r <= lcdc_nxt; stat_r <= stat_nxt; scy_r <= scy_nxt; scx_r <= scx_nxt;
      ly_r <= ly_nxt; lyc_r <= lyc_nxt;
      mono_r <= mono_nxt; wpos_r <= wpos_nxt; pidx_r <= pidx_nxt;
      dot_r <= dot_nxt; fine_r <= fine_nxt; stage_r <= stage_nxt; skip_r <= skip_nxt;
      fcol_r <= fcol_nxt; ocol_r <= ocol_nxt; head_r <= head_nxt; cnt_r <= cnt_nxt;
      vpend_r <= vpend_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    tra_r <= tra_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    fifo_r <= fifo_nxt;
    vkind_r <= vkind_nxt;
    vrow_r <= vrow_nxt;
    vuns_r <= vuns_nxt;
  end

  // The FIFO never holds more than its depth.
  a_fifo_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(FIFO_DEPTH))
    else $error("pixel FIFO count above depth");

  // A late video memory read always follows a read request.
  a_vpend: assert property (@(posedge clk) disable iff (!rst_n)
    vpend_r |-> $past(vreq.en && !vreq.we))
    else $error("late video data without a read");

  // Entering vblank happens only at the end of the last visible line.
  a_vblank: assert property (@(posedge clk) disable iff (!rst_n)
    res.vblank |-> (ly_r == LAST_VIS && dot_r == DOTS_LAST))
    else $error("vblank outside line end");

endmodule

// ===== bench/lpe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_checker
// Watches both channels of the LCD pixel engine, predicts the result of every
// accepted item from its own copy of the engine state and compares each
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lpe_checker
  import lpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_reg_offset,
  input  logic [12:0] in_vram_offset,
  input  logic [7:0]  in_write_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_read_data,
  input  logic        out_pixel_valid,
  input  logic [7:0]  out_pixel_column,
  input  logic [7:0]  out_pixel_row,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic        out_vblank_pulse,
  input  logic        out_frame_done,
  input  logic [1:0]  out_lcd_mode,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [7:0] read_data;
    logic       pixel_valid;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       vblank;
    logic       frame_done;
    logic [1:0] mode;
  } lcd_result_t;

  lcd_result_t expected_results[$];

  // Mirror of the engine state.
  logic        colour_on;
  logic [7:0]  lcdc, stat, scy, scx, ly, lyc;
  logic [7:0]  mono_pal[3];
  logic [7:0]  win_pos[2];
  logic [6:0]  pal_sel[2];
  logic [15:0] pal_ram[64];
  logic [7:0]  vmem[8192];
  int          dot;
  logic [2:0]  fine_x, stage, skip;
  logic [7:0]  fetch_x, out_x;
  logic [12:0] row_ofs;
  logic [1:0]  row_px[8];
  logic [1:0]  fifo[8];
  int          fifo_rd, fifo_cnt;

  assign pending = expected_results.size();

  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  task automatic clear_state();
    colour_on = 1'b0;
    lcdc = '0; stat = '0; scy = '0; scx = '0; ly = '0; lyc = '0;
    foreach (mono_pal[i]) mono_pal[i] = '0;
    foreach (win_pos[i]) win_pos[i] = '0;
    foreach (pal_sel[i]) pal_sel[i] = '0;
    foreach (pal_ram[i]) pal_ram[i] = '0;
    dot = 0; fine_x = '0; stage = '0; skip = '0;
    fetch_x = '0; out_x = '0; row_ofs = '0;
    foreach (row_px[i]) row_px[i] = '0;
    foreach (fifo[i]) fifo[i] = '0;
    fifo_rd = 0; fifo_cnt = 0;
  endtask

  // One step of the background fetcher.
  task automatic fetcher_step();
    logic [7:0]  y, x, id, b;
    logic [12:0] map_ofs;
    int          n;
    case (stage)
      3'd1, 3'd3, 3'd5: stage = stage + 3'd1;
      FS_MAP: begin
        y = scy + ly;
        x = ({scx[7:3], 3'b000} | {5'b0, fine_x}) + fetch_x;
        map_ofs = (lcdc[3] ? MAP_HIGH_OFS : MAP_LOW_OFS) + {3'b0, y[7:3], x[7:3]};
        id = vmem[map_ofs];
        skip = x[2:0];
        row_ofs = {1'b0, id, 4'b0000} + {9'b0, y[2:0], 1'b0};
        if (!lcdc[4] && !id[7]) row_ofs = row_ofs + TILE_SGN_OFS;
        stage = stage + 3'd1;
      end
      FS_LO: begin
        b = vmem[row_ofs];
        for (int k = 0; k < 8 - skip; k++) row_px[k] = {1'b0, b[7 - skip - k]};
        stage = stage + 3'd1;
      end
      FS_HI: begin
        b = vmem[row_ofs + 13'd1];
        for (int k = 0; k < 8 - skip; k++) row_px[k][1] = b[7 - skip - k];
        stage = stage + 3'd1;
      end
      default: begin
        if (fifo_cnt == 0) begin
          n = 8 - skip;
          for (int k = 0; k < n; k++) begin
            fifo[(fifo_rd + fifo_cnt) % 8] = row_px[k];
            fifo_cnt++;
          end
          stage = FS_MAP;
          fetch_x = fetch_x + 8'(n);
        end
      end
    endcase
  endtask

  function automatic logic [7:0] palette_byte(input int which);
    logic [5:0]  idx;
    logic [15:0] v;
    idx = pal_sel[which][5:0];
    v = pal_ram[which * 32 + idx[5:1]];
    return idx[0] ? v[15:8] : v[7:0];
  endfunction

  task automatic palette_store(input int which, input logic [7:0] d);
    logic [5:0] idx;
    int         e;
    idx = pal_sel[which][5:0];
    e = which * 32 + idx[5:1];
    if (idx[0]) pal_ram[e][15:8] = d;
    else pal_ram[e][7:0] = d;
    if (pal_sel[which][6]) pal_sel[which] = {1'b1, idx + 6'd1};
  endtask

  function automatic logic [7:0] register_value(input logic [7:0] ofs);
    case (ofs)
      REG_LCDC: return lcdc;
      REG_STAT: return stat;
      REG_SCY:  return scy;
      REG_SCX:  return scx;
      REG_LY:   return ly;
      REG_LYC:  return lyc;
      REG_BGP:  return mono_pal[0];
      REG_OBP0: return mono_pal[1];
      REG_OBP1: return mono_pal[2];
      REG_WY:   return win_pos[0];
      REG_WX:   return win_pos[1];
      REG_BCPD: return palette_byte(0);
      REG_OCPD: return palette_byte(1);
      default:  return 8'h00;
    endcase
  endfunction

  task automatic register_store(input logic [7:0] ofs, input logic [7:0] d);
    case (ofs)
      REG_LCDC: lcdc = d;
      REG_STAT: stat = {d[7:3], stat[2:0]};
      REG_SCY:  scy = d;
      REG_SCX:  scx = d;
      REG_LYC:  lyc = d;
      REG_BGP:  mono_pal[0] = d;
      REG_OBP0: mono_pal[1] = d;
      REG_OBP1: mono_pal[2] = d;
      REG_WY:   win_pos[0] = d;
      REG_WX:   win_pos[1] = d;
      REG_BCPS: pal_sel[0] = {d[7], d[5:0]};
      REG_BCPD: palette_store(0, d);
      REG_OCPS: pal_sel[1] = {d[7], d[5:0]};
      REG_OCPD: palette_store(1, d);
      default: ;
    endcase
  endtask

  // Advance the dot and line timers by one dot and emit at most one pixel.
  task automatic dot_step(inout lcd_result_t r);
    int          line;
    logic [1:0]  c;
    logic [15:0] rgb;
    line = ly;
    stat[2] = (ly == lyc);
    if (line < 144) begin
      if (dot == 0) fine_x = scx[2:0];
      if (dot > 80 && stat[1:0] == MODE_DRAW) begin
        fetcher_step();
        if (dot == 368) stat[1:0] = MODE_HBLANK;
      end
      if (out_x < 160 && fifo_cnt > 0) begin
        c = fifo[fifo_rd];
        fifo_rd = (fifo_rd + 1) % 8;
        fifo_cnt--;
        if (colour_on) rgb = pal_ram[c];
        else rgb = {1'b0, grey_shade(mono_pal[0][c * 2 +: 2])};
        r.pixel_valid = 1'b1;
        r.column = out_x;
        r.row = 8'(line);
        r.red = widen5(rgb[4:0]);
        r.green = widen5(rgb[9:5]);
        r.blue = widen5(rgb[14:10]);
        out_x++;
      end
    end
    dot++;
    if (dot >= 456) begin
      line++;
      if (line == 144) begin
        stat[1:0] = MODE_VBLANK;
        r.vblank = 1'b1;
      end else if (line >= 154) begin
        line = 0;
        stat[1:0] = MODE_OAM;
      end else if (line < 144) begin
        stat[1:0] = MODE_OAM;
      end
      dot = 0;
      fetch_x = '0;
      ly = 8'(line);
    end else if (dot == 80 && line < 144) begin
      stat[1:0] = MODE_DRAW;
      fifo_rd = 0;
      fifo_cnt = 0;
      out_x = '0;
      stage = FS_MAP;
    end
    r.frame_done = (out_x == 160 && ly == 143);
  endtask

  // Predict on every accepted item, compare on every accepted result.
  always @(posedge clk) begin
    lcd_result_t r, e;
    if (!rst_n) begin
      clear_state();
      expected_results.delete();
      errors <= 0;
    end else begin
      if (cfg_we) colour_on = cfg_wdata;
      if (in_valid && !in_stall) begin
        r = '{default: '0};
        case (op_t'(in_opcode))
          OP_RD:  r.read_data = register_value(in_reg_offset);
          OP_WR:  register_store(in_reg_offset, in_write_data);
          OP_VWR: vmem[in_vram_offset] = in_write_data;
          default: dot_step(r);
        endcase
        r.mode = stat[1:0];
        expected_results.push_back(r);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no item outstanding");
          errors <= errors + 1;
        end else begin
          e = expected_results.pop_front();
          if (out_read_data !== e.read_data ||
              out_pixel_valid !== e.pixel_valid ||
              out_pixel_column !== e.column || out_pixel_row !== e.row ||
              out_red !== e.red || out_green !== e.green || out_blue !== e.blue ||
              out_vblank_pulse !== e.vblank || out_frame_done !== e.frame_done ||
              out_lcd_mode !== e.mode) begin
            errors <= errors + 1;
            if (out_read_data !== e.read_data)
              $error("read_data expected %0h actual %0h", e.read_data, out_read_data);
            if (out_pixel_valid !== e.pixel_valid)
              $error("pixel_valid expected %0h actual %0h", e.pixel_valid, out_pixel_valid);
            if (out_pixel_column !== e.column)
              $error("pixel_column expected %0d actual %0d", e.column, out_pixel_column);
            if (out_pixel_row !== e.row)
              $error("pixel_row expected %0d actual %0d", e.row, out_pixel_row);
            if (out_red !== e.red)
              $error("red expected %0h actual %0h", e.red, out_red);
            if (out_green !== e.green)
              $error("green expected %0h actual %0h", e.green, out_green);
            if (out_blue !== e.blue)
              $error("blue expected %0h actual %0h", e.blue, out_blue);
            if (out_vblank_pulse !== e.vblank)
              $error("vblank_pulse expected %0h actual %0h", e.vblank, out_vblank_pulse);
            if (out_frame_done !== e.frame_done)
              $error("frame_done expected %0h actual %0h", e.frame_done, out_frame_done);
            if (out_lcd_mode !== e.mode)
              $error("lcd_mode expected %0d actual %0d", e.mode, out_lcd_mode);
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_handheld_lcd_pixel_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handheld_lcd_pixel_engine
// Drives dot ticks, register accesses and video memory writes into the LCD
// pixel engine under random idling and stalls, in mono and colour mode, and
// takes the verdict from the checker beside the block.
// ----------------------------------------------------------------------------
module tb_handheld_lcd_pixel_engine;
  import lpe_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we, cfg_wdata;
  logic        in_valid, in_stall;
  logic [1:0]  in_opcode;
  logic [7:0]  in_reg_offset;
  logic [12:0] in_vram_offset;
  logic [7:0]  in_write_data;
  logic        out_valid, out_stall;
  logic [7:0]  out_read_data;
  logic        out_pixel_valid;
  logic [7:0]  out_pixel_column, out_pixel_row;
  logic [7:0]  out_red, out_green, out_blue;
  logic        out_vblank_pulse, out_frame_done;
  logic [1:0]  out_lcd_mode;
  int          errors, pending;

  // Quiet mode removes idling on the item side and makes result stalls rare; hold asks for one long stall.
  logic quiet;
  logic hold_req;

  localparam logic [7:0] MappedRegs[15] = '{REG_LCDC, REG_STAT, REG_SCY, REG_SCX, REG_LY,
    REG_LYC, REG_BGP, REG_OBP0, REG_OBP1, REG_WY, REG_WX, REG_BCPS, REG_BCPD, REG_OCPS,
    REG_OCPD};

  // The fetcher stays on the first row of the high tile map, which names
  // only tiles zero to seven of the unsigned tile area.
  localparam logic [12:0] MapRowBase = MAP_HIGH_OFS;

  handheld_lcd_pixel_engine i_dut (.*);

  lpe_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("handheld_lcd_pixel_engine test failed");
    $finish;
  end

  // Result side: random stall per item, plus one long hold on request.
  initial begin
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      int n;
      if (hold_req) n = 300;
      else if (quiet) n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 6) : 0;
      else n = $urandom_range(0, 6);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one item and return at the edge that accepts it.
  task automatic send_item(input op_t op, input logic [7:0] ro, input logic [12:0] vo,
                           input logic [7:0] wd);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_reg_offset <= ro;
    in_vram_offset <= vo;
    in_write_data <= wd;
    do @(posedge clk); while (in_stall);
  endtask

  // Wait until every result is back, then write the colour mode.
  task automatic set_colour_mode(input logic v);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random item; tick_pct sets the share of dot ticks.
  task automatic random_item(input int tick_pct);
    int          p;
    logic [7:0]  ro, wd;
    logic [12:0] vo;
    p = $urandom_range(0, 99);
    ro = ($urandom_range(0, 3) == 0) ? 8'($urandom) : MappedRegs[$urandom_range(0, 14)];
    wd = 8'($urandom);
    vo = 13'($urandom);
    if (p < tick_pct)
      send_item(OP_TICK, 8'($urandom), vo, wd);
    else if (p < tick_pct + (100 - tick_pct) / 3)
      send_item(OP_RD, ro, vo, wd);
    else if (p < tick_pct + 2 * (100 - tick_pct) / 3) begin
      // Keep the fetcher on the written map row and tiles.
      if (ro == REG_LCDC) wd = wd | 8'h18;
      else if (ro == REG_SCY) wd = wd & 8'h03;
      send_item(OP_WR, ro, vo, wd);
    end else begin
      if (vo >= MapRowBase && vo < MapRowBase + 13'd32) wd = wd & 8'h07;
      send_item(OP_VWR, 8'($urandom), vo, wd);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_TICK;
    in_reg_offset = '0;
    in_vram_offset = '0;
    in_write_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_colour_mode(1'b0);

    // Fill the tiles and the map row that the fetcher reads.
    quiet = 1'b1;
    for (int a = 0; a < 128; a++)
      send_item(OP_VWR, 8'($urandom), 13'(a), 8'($urandom));
    for (int a = 0; a < 32; a++)
      send_item(OP_VWR, 8'($urandom), MapRowBase + 13'(a), 8'($urandom_range(0, 7)));
    quiet = 1'b0;

    // Directed: register extremes, read-only bits, palette wrap, unmapped.
    send_item(OP_WR, REG_STAT, 13'h1FFF, 8'hFF);
    send_item(OP_RD, REG_STAT, 13'h0000, 8'h00);
    send_item(OP_WR, REG_LY, 13'h0000, 8'hFF);
    send_item(OP_RD, REG_LY, 13'h0000, 8'h00);
    send_item(OP_WR, 8'h46, 13'h0000, 8'hFF);
    send_item(OP_RD, 8'h46, 13'h0000, 8'h00);
    send_item(OP_RD, 8'hFF, 13'h1FFF, 8'hFF);
    send_item(OP_WR, REG_BCPS, 13'h0000, 8'hBF);
    send_item(OP_WR, REG_BCPD, 13'h0000, 8'hFF);
    send_item(OP_RD, REG_BCPS, 13'h0000, 8'h00);
    send_item(OP_RD, REG_BCPD, 13'h0000, 8'h00);
    send_item(OP_WR, REG_BCPD, 13'h0000, 8'h00);
    send_item(OP_WR, REG_OCPS, 13'h0000, 8'h3F);
    send_item(OP_WR, REG_OCPD, 13'h0000, 8'hA5);
    send_item(OP_RD, REG_OCPD, 13'h0000, 8'h00);
    send_item(OP_WR, REG_BGP, 13'h0000, 8'hE4);
    send_item(OP_WR, REG_LCDC, 13'h0000, 8'h18);
    send_item(OP_WR, REG_SCX, 13'h0000, 8'hFF);
    send_item(OP_VWR, 8'h00, 13'h0000, 8'h00);
    send_item(OP_VWR, 8'h00, 13'h1FFF, 8'hFF);
    for (int i = 0; i < 5; i++) send_item(OP_TICK, 8'h00, 13'h0000, 8'h00);

    // Random mix in colour mode with a long result hold and a drain pause.
    set_colour_mode(1'b1);
    for (int i = 0; i < 900; i++) begin
      if (i == 300) hold_req = 1'b1;
      if (i == 310) hold_req = 1'b0;
      if (i == 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      random_item(70);
    end

    // Mostly dot ticks in mono mode, so the fetcher draws whole lines.
    set_colour_mode(1'b0);
    for (int i = 0; i < 865; i++) random_item(80);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) $display("handheld_lcd_pixel_engine test passed");
    else $display("handheld_lcd_pixel_engine test failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/lpe_pkg.sv
design/lpe_vram.sv
design/lpe_cpal.sv
design/lpe_engine.sv
design/handheld_lcd_pixel_engine.sv
bench/lpe_checker.sv
bench/tb_handheld_lcd_pixel_engine.sv
